// File: rtl/bfs_pkg.sv
// Shared types and constants for the box filter smoothing block.
`timescale 1ns / 1ps
`default_nettype none

package bfs_pkg;

	// Defaults for the top-level parameters
	localparam int KERNEL_SIDE_DEF = 3;
	localparam int MAX_WIDTH_DEF   = 2048;
	localparam int MAX_HEIGHT      = 2048;

	// Field widths
	localparam int PIX_W = 8;
	localparam int CFG_W = 12;

	// Register reset values
	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

	// Result queue depth (power of two)
	localparam int OUT_DEPTH = 8;

	// Register indexes on the configuration port
	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} bfs_reg_t;

	// Input item
	typedef struct packed {
		logic [PIX_W-1:0] gray_pixel;
		logic             frame_start;
	} bfs_in_t;

	// Result item
	typedef struct packed {
		logic [PIX_W-1:0] smoothed_pixel;
		logic             frame_end;
	} bfs_out_t;

	// Per-item flags that ride down the pipeline
	typedef struct packed {
		logic produce;
		logic frame_end;
	} bfs_flag_t;

endpackage

`default_nettype wire

// File: rtl/bfs_line.sv
// One line-store cell: a row of past pixels, read and rewritten at the current column.
`timescale 1ns / 1ps
`default_nettype none

module bfs_line #(
	parameter int KERNEL_SIDE = bfs_pkg::KERNEL_SIDE_DEF,
	parameter int MAX_WIDTH   = bfs_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                                              clk,
	input  wire logic                                              arst_n,
	input  wire logic                                              wr_en,
	input  wire logic [$clog2(MAX_WIDTH+KERNEL_SIDE-1)-1:0]        rd_addr,
	input  wire logic [$clog2(MAX_WIDTH+KERNEL_SIDE-1)-1:0]        wr_addr,
	input  wire logic [bfs_pkg::PIX_W-1:0]                         wr_pix,
	output logic      [bfs_pkg::PIX_W-1:0]                         rd_pix
);
	import bfs_pkg::*;

	localparam int PAD = MAX_WIDTH + KERNEL_SIDE - 1;

	logic [PIX_W-1:0] mem [PAD];
	logic [PIX_W-1:0] rd_q;
	logic             fwd_q;
	logic [PIX_W-1:0] fwd_pix_q;

	// Line memory: one write and one registered read per clock
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_pix;
		end
		rd_q <= mem[rd_addr];
	end

	// Same-column write in the read cycle (frame restart on column 0)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_pix_q <= wr_pix;
	end

	assign rd_pix = fwd_q ? fwd_pix_q : rd_q;

endmodule

`default_nettype wire

// File: rtl/bfs_row.sv
// One window-row cell: K pixel registers sliding left, with a registered row sum.
`timescale 1ns / 1ps
`default_nettype none

module bfs_row #(
	parameter int KERNEL_SIDE = bfs_pkg::KERNEL_SIDE_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   shift_en,
	input  wire logic [bfs_pkg::PIX_W-1:0]              col_pix,
	output logic      [$clog2(255*KERNEL_SIDE+1)-1:0]   row_sum
);
	import bfs_pkg::*;

	localparam int RS_W = $clog2(255 * KERNEL_SIDE + 1);

	logic [PIX_W-1:0] win_q [KERNEL_SIDE];
	logic [RS_W-1:0]  sum_c;
	logic [RS_W-1:0]  row_sum_q;

	// Slide left, new column pixel enters on the right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KERNEL_SIDE; k++) begin
				win_q[k] <= '0;
			end
		end else if (shift_en) begin
			for (int k = 0; k < KERNEL_SIDE - 1; k++) begin
				win_q[k] <= win_q[k+1];
			end
			win_q[KERNEL_SIDE-1] <= col_pix;
		end
	end

	// Row sum
	always_comb begin
		sum_c = '0;
		for (int k = 0; k < KERNEL_SIDE; k++) begin
			sum_c = sum_c + RS_W'(win_q[k]);
		end
	end

	always_ff @(posedge clk) begin
		row_sum_q <= sum_c;
	end

	assign row_sum = row_sum_q;

endmodule

`default_nettype wire

// File: rtl/bfs_mean.sv
// Window total and divide by K*K through a constant reciprocal multiply.
`timescale 1ns / 1ps
`default_nettype none

module bfs_mean #(
	parameter int KERNEL_SIDE = bfs_pkg::KERNEL_SIDE_DEF
) (
	input  wire logic                                                    clk,
	input  wire logic                                                    arst_n,
	input  wire logic [KERNEL_SIDE-1:0][$clog2(255*KERNEL_SIDE+1)-1:0]   row_sums,
	input  wire bfs_pkg::bfs_flag_t                                      flag_in,
	output logic                                                         push,
	output bfs_pkg::bfs_out_t                                            push_item
);
	import bfs_pkg::*;

	localparam int DIV    = KERNEL_SIDE * KERNEL_SIDE;
	localparam int SUM_W  = $clog2(255 * DIV + 1);
	localparam int DIV_L  = $clog2(DIV);
	localparam int SHIFT  = SUM_W + DIV_L;
	// ceil(2^SHIFT / DIV): exact quotient for every SUM_W-bit total
	localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);
	localparam int M_W    = $clog2(RECIP + 64'd1);
	localparam int PROD_W = SUM_W + M_W;
	localparam logic [M_W-1:0] RECIP_M = M_W'(RECIP);

	logic [SUM_W-1:0]  total_c;
	logic [SUM_W-1:0]  sum_s4;
	logic [PROD_W-1:0] prod_s5;
	bfs_flag_t         flag_s4;
	bfs_flag_t         flag_s5;

	// Sum of row sums
	always_comb begin
		total_c = '0;
		for (int r = 0; r < KERNEL_SIDE; r++) begin
			total_c = total_c + SUM_W'(row_sums[r]);
		end
	end

	always_ff @(posedge clk) begin
		sum_s4  <= total_c;
		prod_s5 <= PROD_W'(sum_s4) * PROD_W'(RECIP_M);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_s4 <= '0;
			flag_s5 <= '0;
		end else begin
			flag_s4 <= flag_in;
			flag_s5 <= flag_s4;
		end
	end

	// Mean is at most 255, so the quotient fits the pixel field
	assign push                     = flag_s5.produce;
	assign push_item.smoothed_pixel = prod_s5[SHIFT +: PIX_W];
	assign push_item.frame_end      = flag_s5.frame_end;

endmodule

`default_nettype wire

// File: rtl/bfs_fifo.sv
// Result queue between the pipeline and the output channel.
`timescale 1ns / 1ps
`default_nettype none

module bfs_fifo (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     push,
	input  wire bfs_pkg::bfs_out_t                        push_item,
	input  wire logic                                     pop_ready,
	output logic                                          out_valid,
	output bfs_pkg::bfs_out_t                             out_item,
	output logic      [$clog2(bfs_pkg::OUT_DEPTH+1)-1:0]  fill
);
	import bfs_pkg::*;

	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);

	bfs_out_t         slot_q [OUT_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && pop_ready;
	assign out_item  = slot_q[rptr_q];
	assign fill      = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_item;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/box_filter_smoothing.sv
// Top level of the K-by-K valid-mode box filter over a padded gray pixel stream.
//
//   channel   direction   handshake                payload
//   src       in          src_valid / src_ready    src_item  (gray_pixel, frame_start)
//   res       out         res_valid / res_ready    res_item  (smoothed_pixel, frame_end)
//   apb       in/out      psel/penable/pready      paddr, pwdata, prdata
//
// One item per clock sustained while queue credits remain; one line-store read and write per clock per row sets it.
// A result passes pipeline stages s1 to s5 and then the result queue before it shows on res.
// src_ready follows a credit count for an 8-entry result queue, so the input keeps
// flowing while results wait; it drops only when 8 results are queued or in flight.
// Reset is asynchronous; line stores are not cleared, entries are written before use.
`timescale 1ns / 1ps
`default_nettype none

module box_filter_smoothing #(
	parameter int KERNEL_SIDE = bfs_pkg::KERNEL_SIDE_DEF,
	parameter int MAX_WIDTH   = bfs_pkg::MAX_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               src_valid,
	output logic                    src_ready,
	input  wire bfs_pkg::bfs_in_t   src_item,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output bfs_pkg::bfs_out_t       res_item,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);
	import bfs_pkg::*;

	localparam int PAD    = MAX_WIDTH + KERNEL_SIDE - 1;
	localparam int ADDR_W = $clog2(PAD);
	localparam int CW     = $clog2(MAX_WIDTH + KERNEL_SIDE);
	localparam int RW     = $clog2(MAX_HEIGHT + KERNEL_SIDE);
	localparam int RS_W   = $clog2(255 * KERNEL_SIDE + 1);
	localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
	localparam int W_RST  = (int'(FRAME_WIDTH_RST) > MAX_WIDTH) ? MAX_WIDTH
	                        : int'(FRAME_WIDTH_RST);
	localparam int H_RST  = (int'(FRAME_HEIGHT_RST) > MAX_HEIGHT) ? MAX_HEIGHT
	                        : int'(FRAME_HEIGHT_RST);

	// Configuration
	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;
	logic [CW-1:0]    pad_w_q;
	logic [RW-1:0]    pad_h_q;
	logic [CFG_W-1:0] wr_val;
	logic [CW-1:0]    fw_c;
	logic [RW-1:0]    fh_c;
	logic             cfg_wr;

	// Position counters and stage-0 decode
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_a;
	logic [CW-1:0] col_b;
	logic [CW-1:0] col_inc;
	logic [CW-1:0] col_n;
	logic [RW-1:0] row_a;
	logic [RW-1:0] row_b;
	logic [RW-1:0] row_c;
	logic [RW-1:0] row_n;
	logic          produce0;
	logic          fend0;
	logic          accept;

	// Pipeline
	logic                     valid_s1;
	bfs_flag_t                flag_s1;
	bfs_flag_t                flag_s2;
	bfs_flag_t                flag_s3;
	logic [PIX_W-1:0]         pix_s1;
	logic [ADDR_W-1:0]        col_s1;
	logic [KERNEL_SIDE-1:0][PIX_W-1:0] col_vec;
	logic [KERNEL_SIDE-1:0][RS_W-1:0]  row_sums;

	// Result queue and credits
	logic             mean_push;
	bfs_out_t         mean_item;
	logic [CNT_W-1:0] fifo_fill;
	logic [CNT_W-1:0] credit_q;
	logic             take;
	logic             pop;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign wr_val = pwdata[CFG_W-1:0];

	// Clamp written sizes and add the border
	always_comb begin
		if (wr_val == '0) begin
			fw_c = CW'(1);
		end else if (int'(wr_val) > MAX_WIDTH) begin
			fw_c = CW'(MAX_WIDTH);
		end else begin
			fw_c = CW'(wr_val);
		end
		if (wr_val == '0) begin
			fh_c = RW'(1);
		end else if (int'(wr_val) > MAX_HEIGHT) begin
			fh_c = RW'(MAX_HEIGHT);
		end else begin
			fh_c = RW'(wr_val);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			pad_w_q        <= CW'(W_RST + KERNEL_SIDE - 1);
			pad_h_q        <= RW'(H_RST + KERNEL_SIDE - 1);
		end else if (cfg_wr) begin
			case (bfs_reg_t'(paddr[2]))
				REG_FRAME_WIDTH: begin
					frame_width_q <= wr_val;
					pad_w_q       <= fw_c + CW'(KERNEL_SIDE - 1);
				end
				REG_FRAME_HEIGHT: begin
					frame_height_q <= wr_val;
					pad_h_q        <= fh_c + RW'(KERNEL_SIDE - 1);
				end
				default: begin
					frame_width_q <= frame_width_q;
				end
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (bfs_reg_t'(paddr[2]))
			REG_FRAME_WIDTH:  prdata = {{(32-CFG_W){1'b0}}, frame_width_q};
			REG_FRAME_HEIGHT: prdata = {{(32-CFG_W){1'b0}}, frame_height_q};
			default:          prdata = '0;
		endcase
	end

	// ---------------- stage 0: position of this pixel ----------------
	assign accept = src_valid && src_ready;
	assign pop    = res_valid && res_ready;

	always_comb begin
		col_a = src_item.frame_start ? '0 : col_q;
		row_a = src_item.frame_start ? '0 : row_q;
		// column past a shrunk width ends the row
		if (col_a >= pad_w_q) begin
			col_b = '0;
			row_b = row_a + RW'(1);
		end else begin
			col_b = col_a;
			row_b = row_a;
		end
		row_c    = (row_b >= pad_h_q) ? '0 : row_b;
		produce0 = (row_c >= RW'(KERNEL_SIDE - 1)) && (col_b >= CW'(KERNEL_SIDE - 1));
		fend0    = (row_c == pad_h_q - RW'(1)) && (col_b == pad_w_q - CW'(1));
		// advance for the next pixel
		col_inc = col_b + CW'(1);
		if (col_inc >= pad_w_q) begin
			col_n = '0;
			row_n = row_c + RW'(1);
			if (row_n >= pad_h_q) begin
				row_n = '0;
			end
		end else begin
			col_n = col_inc;
			row_n = row_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_n;
			row_q <= row_n;
		end
	end

	// ---------------- pipeline control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			flag_s1  <= '0;
			flag_s2  <= '0;
			flag_s3  <= '0;
		end else begin
			valid_s1          <= accept;
			flag_s1.produce   <= accept && produce0;
			flag_s1.frame_end <= accept && fend0;
			flag_s2           <= flag_s1;
			flag_s3           <= flag_s2;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= src_item.gray_pixel;
		col_s1 <= col_b[ADDR_W-1:0];
	end

	// ---------------- chain of line and window cells ----------------
	assign col_vec[KERNEL_SIDE-1] = pix_s1;

	for (genvar r = 0; r < KERNEL_SIDE - 1; r++) begin : g_line
		bfs_line #(
			.KERNEL_SIDE (KERNEL_SIDE),
			.MAX_WIDTH   (MAX_WIDTH)
		) u_line (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (valid_s1),
			.rd_addr (col_b[ADDR_W-1:0]),
			.wr_addr (col_s1),
			.wr_pix  (col_vec[r+1]),
			.rd_pix  (col_vec[r])
		);
	end

	for (genvar r = 0; r < KERNEL_SIDE; r++) begin : g_row
		bfs_row #(
			.KERNEL_SIDE (KERNEL_SIDE)
		) u_row (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (valid_s1),
			.col_pix  (col_vec[r]),
			.row_sum  (row_sums[r])
		);
	end

	// ---------------- mean and result queue ----------------
	bfs_mean #(
		.KERNEL_SIDE (KERNEL_SIDE)
	) u_mean (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_sums  (row_sums),
		.flag_in   (flag_s3),
		.push      (mean_push),
		.push_item (mean_item)
	);

	bfs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (mean_push),
		.push_item (mean_item),
		.pop_ready (res_ready),
		.out_valid (res_valid),
		.out_item  (res_item),
		.fill      (fifo_fill)
	);

	// Credits: one queue slot reserved per result-producing item
	assign take      = accept && produce0;
	assign src_ready = (credit_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CNT_W'(OUT_DEPTH);
		end else begin
			case ({take, pop})
				2'b10:   credit_q <= credit_q - CNT_W'(1);
				2'b01:   credit_q <= credit_q + CNT_W'(1);
				default: credit_q <= credit_q;
			endcase
		end
	end

	// ---------------- assertions ----------------
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(credit_q) + 32'(fifo_fill)) <= OUT_DEPTH)
		else $error("credits plus queued results exceed queue depth");

	a_fend_produces: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && fend0) |-> produce0)
		else $error("frame end on a position without a full window");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		mean_push |-> ((fifo_fill != CNT_W'(OUT_DEPTH)) || res_ready))
		else $error("result pushed into a full queue");

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the 3x3 box filter: directed frames, size extremes, random frames.
`timescale 1ns / 1ps

module tb;
	import bfs_pkg::*;

	localparam int KSIDE       = KERNEL_SIDE_DEF;
	localparam int WIN_PIX     = KSIDE * KSIDE;
	localparam int PADW        = MAX_WIDTH_DEF + KSIDE - 1;
	localparam int RES_LAT     = 5;
	localparam int SETTLE      = 4 * RES_LAT;
	localparam int EXTREME_PIX = 64;
	localparam int RANDOM_PIX  = 1550;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT  = 5000;
	localparam int PRINT_CAP   = 40;

	typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;
	typedef enum {PIX_ANY, PIX_BRIGHT, PIX_BINARY} pix_style_t;
	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} stall_mode_t;

	// one directed step: a register write or a pixel, maybe with its result pinned
	typedef struct packed {
		row_kind_t        kind;
		bfs_reg_t         sel;
		logic [CFG_W-1:0] value;
		logic [PIX_W-1:0] pix;
		logic             start;
		logic             pinned;
		logic [PIX_W-1:0] mean;
		logic             frame_end;
	} warm_row_t;

	// per-pixel note: a hand-written result overrides the predicted one
	typedef struct packed {
		logic     pinned;
		bfs_out_t result;
	} pin_t;

	// both sizes saturate to one, so every frame below is a single 3x3 window
	localparam warm_row_t WARM_ROWS [22] = '{
		'{ROW_WRITE, REG_FRAME_WIDTH,  12'd0, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
		'{ROW_WRITE, REG_FRAME_HEIGHT, 12'd0, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
		// all-white frame
		'{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0, 8'd255, 1'b1, 1'b0, 8'd0,   1'b0},
		'{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
		'{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
		'{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
		'{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
		'{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
		'{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
		'{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
		'{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0, 8'd255, 1'b0, 1'b1, 8'd255, 1'b1},
		// unmarked frame after the wrap, cut short
		'{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0, 8'd13,  1'b0, 1'b0, 8'd0,   1'b0},
		'{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0, 8'd77,  1'b0, 1'b0, 8'd0,   1'b0},
		// restart mid-frame; window sum of 8 truncates to zero
		'{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0, 8'd8,   1'b1, 1'b0, 8'd0,   1'b0},
		'{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
		'{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
		'{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
		'{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
		'{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
		'{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
		'{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
		'{ROW_PIXEL, REG_FRAME_WIDTH,  12'd0, 8'd0,   1'b0, 1'b1, 8'd0,   1'b1}
	};

	logic        clk;
	logic        arst_n;
	logic        src_valid;
	logic        src_ready;
	bfs_in_t     src_item;
	logic        res_valid;
	logic        res_ready = 1'b0;
	bfs_out_t    res_item;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// model's view of the filter registers and its storage
	logic [CFG_W-1:0] width_reg  = FRAME_WIDTH_RST;
	logic [CFG_W-1:0] height_reg = FRAME_HEIGHT_RST;
	bit [PIX_W-1:0]   line_mem [KSIDE-1][PADW];
	bit [PIX_W-1:0]   win [KSIDE][KSIDE];
	int unsigned      col_pos;
	int unsigned      row_pos;

	bfs_out_t    mean_q [$];
	pin_t        pin_q [$];
	int unsigned pixel_count;
	int unsigned mean_count;
	int unsigned frame_count;
	int unsigned write_count;
	int unsigned fail_count;
	int unsigned idle_cycles;

	// sender and receiver pacing
	int          burst_left;
	bit          steady;
	bit          hold_req;
	stall_mode_t stall_mode;
	int          mode_left;
	int unsigned stall_tick;

	box_filter_smoothing i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int unsigned dim_clamp(input logic [CFG_W-1:0] v, input int unsigned hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	// padded pixel count of one frame at the current sizes
	function automatic int unsigned padded_pixels();
		return (dim_clamp(width_reg, MAX_WIDTH_DEF) + KSIDE - 1) *
			(dim_clamp(height_reg, MAX_HEIGHT) + KSIDE - 1);
	endfunction

	// one pixel through the line stores and window; yields the window mean when complete
	task automatic slide_window(input bfs_in_t px, output bit made, output bfs_out_t mean);
		int unsigned    pw;
		int unsigned    ph;
		int unsigned    c;
		int unsigned    sum;
		bit [PIX_W-1:0] col [KSIDE];
		pw = dim_clamp(width_reg, MAX_WIDTH_DEF) + KSIDE - 1;
		ph = dim_clamp(height_reg, MAX_HEIGHT) + KSIDE - 1;
		made = 1'b0;
		mean = '0;
		if (px.frame_start) begin
			col_pos = 0;
			row_pos = 0;
		end
		// positions left over from larger sizes end the row or the frame
		if (col_pos >= pw) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= ph)
			row_pos = 0;
		c = col_pos;

		// column of stored rows plus the new pixel; stores shift up one row
		for (int r = 0; r < KSIDE - 1; r++)
			col[r] = line_mem[r][c];
		col[KSIDE-1] = px.gray_pixel;
		for (int r = 0; r < KSIDE - 1; r++)
			line_mem[r][c] = col[r+1];

		sum = 0;
		for (int r = 0; r < KSIDE; r++) begin
			for (int k = 0; k < KSIDE - 1; k++)
				win[r][k] = win[r][k+1];
			win[r][KSIDE-1] = col[r];
			for (int k = 0; k < KSIDE; k++)
				sum += win[r][k];
		end

		if (row_pos >= KSIDE - 1 && c >= KSIDE - 1) begin
			made = 1'b1;
			mean.smoothed_pixel = PIX_W'(sum / WIN_PIX);
			mean.frame_end = (row_pos == ph - 1 && c == pw - 1);
		end

		col_pos = c + 1;
		if (col_pos >= pw) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= ph)
				row_pos = 0;
		end
	endtask

	// handshake monitor: predict on accepted pixels, check accepted results
	always @(posedge clk) begin
		bit       made;
		bfs_out_t mean;
		bfs_out_t want;
		pin_t     pin;
		if (arst_n) begin
			if (src_valid && src_ready) begin
				pin = (pin_q.size() != 0) ? pin_q.pop_front() : '0;
				slide_window(src_item, made, mean);
				pixel_count++;
				if (pin.pinned)
					mean_q.push_back(pin.result);
				else if (made)
					mean_q.push_back(mean);
			end

			if (res_valid && res_ready) begin
				if (mean_q.size() == 0) begin
					fail_count++;
					if (fail_count <= PRINT_CAP)
						$display("%0t: expected no result, got pixel %0d frame_end %0b",
							$time, res_item.smoothed_pixel, res_item.frame_end);
				end else begin
					want = mean_q.pop_front();
					mean_count++;
					if (want.frame_end)
						frame_count++;
					if (res_item.smoothed_pixel !== want.smoothed_pixel) begin
						fail_count++;
						if (fail_count <= PRINT_CAP)
							$display("%0t: smoothed_pixel expected %0d, got %0d",
								$time, want.smoothed_pixel, res_item.smoothed_pixel);
					end
					if (res_item.frame_end !== want.frame_end) begin
						fail_count++;
						if (fail_count <= PRINT_CAP)
							$display("%0t: frame_end expected %0b, got %0b",
								$time, want.frame_end, res_item.frame_end);
					end
				end
			end

			// watchdog on cycles where neither channel moves an item
			if ((src_valid && src_ready) || (res_valid && res_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// result side: stall pattern changes at random intervals; long hold on request
	always begin
		@(posedge clk);
		if (hold_req) begin
			res_ready <= 1'b0;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_req = 1'b0;
		end else begin
			if (mode_left <= 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(32, 256);
			end
			mode_left--;
			stall_tick++;
			case (stall_mode)
				RX_OPEN:   res_ready <= 1'b1;
				RX_COIN:   res_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: res_ready <= (stall_tick % 4 == 0);
				default:   res_ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// offer one pixel in the current burst; returns at the edge it is accepted
	task automatic offer_pixel(input logic [PIX_W-1:0] pix, input logic start, input pin_t pin);
		int gap;
		if (!steady && burst_left <= 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				src_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		pin_q.push_back(pin);
		src_valid <= 1'b1;
		src_item <= '{gray_pixel: pix, frame_start: start};
		do @(posedge clk); while (!src_ready);
	endtask

	// stop offering and let every expected result and stray late one come out
	task automatic settle();
		src_valid <= 1'b0;
		do @(posedge clk); while (mean_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// APB write: setup then access; upper data bits are don't-care
	task automatic write_reg(input bfs_reg_t sel, input logic [CFG_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= {20'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (sel == REG_FRAME_WIDTH)
			width_reg = value;
		else
			height_reg = value;
		write_count++;
	endtask

	function automatic logic [PIX_W-1:0] pick_pixel(input pix_style_t style);
		case (style)
			PIX_BRIGHT: return PIX_W'($urandom_range(240, 255));
			PIX_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default:    return PIX_W'($urandom);
		endcase
	endfunction

	// mostly small sizes; zero checks the low saturation
	function automatic logic [CFG_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0:             return '0;
			1, 2, 3, 4, 5: return CFG_W'($urandom_range(1, 8));
			6, 7:          return CFG_W'($urandom_range(9, 24));
			default:       return CFG_W'($urandom_range(1, 3));
		endcase
	endfunction

	// a run of pixels; strays put a frame start somewhere inside
	task automatic send_frame(input int unsigned count, input bit marked, input bit strays);
		pix_style_t style;
		bit         start;
		style = pix_style_t'($urandom_range(0, 2));
		for (int unsigned i = 0; i < count; i++) begin
			start = (i == 0) ? marked : (strays && $urandom_range(0, 399) == 0);
			offer_pixel(pick_pixel(style), start, '0);
		end
	endtask

	initial begin
		int unsigned n;
		int unsigned random_sent;
		int unsigned phase;
		int unsigned frames;
		bit          cut;
		src_valid <= 1'b0;
		src_item <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (WARM_ROWS[i]) begin
			if (WARM_ROWS[i].kind == ROW_WRITE) begin
				settle();
				write_reg(WARM_ROWS[i].sel, WARM_ROWS[i].value);
			end else begin
				offer_pixel(WARM_ROWS[i].pix, WARM_ROWS[i].start,
					{WARM_ROWS[i].pinned, WARM_ROWS[i].mean, WARM_ROWS[i].frame_end});
			end
		end

		// widest frame (width saturates high), cut inside the first row
		settle();
		steady = 1'b1;
		write_reg(REG_FRAME_WIDTH, '1);
		write_reg(REG_FRAME_HEIGHT, '0);
		send_frame(EXTREME_PIX, 1'b1, 1'b0);

		// tallest frame (height saturates high), one output column, cut after a few rows
		settle();
		write_reg(REG_FRAME_WIDTH, 12'd1);
		write_reg(REG_FRAME_HEIGHT, 12'd2049);
		send_frame(EXTREME_PIX, 1'b1, 1'b0);

		// random phases; a cut frame carries on under the next phase's sizes
		random_sent = 0;
		phase = 0;
		while (random_sent < RANDOM_PIX || phase < 3) begin
			settle();
			steady = ($urandom_range(0, 4) == 0);
			if (phase == 2) begin
				// results held off while pixels keep coming, so the input backs up
				write_reg(REG_FRAME_WIDTH, 12'd6);
				write_reg(REG_FRAME_HEIGHT, 12'd6);
				hold_req = 1'b1;
			end else begin
				case ($urandom_range(0, 2))
					0: write_reg(REG_FRAME_WIDTH, pick_size());
					1: write_reg(REG_FRAME_HEIGHT, pick_size());
					default: begin
						write_reg(REG_FRAME_WIDTH, pick_size());
						write_reg(REG_FRAME_HEIGHT, pick_size());
					end
				endcase
			end
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				n = padded_pixels();
				cut = (phase != 2 && f == frames - 1 && $urandom_range(0, 3) == 0);
				if (cut)
					n = $urandom_range(1, n);
				send_frame(n, $urandom_range(0, 4) != 0, phase != 2);
				random_sent += n;
			end
			phase++;
		end

		settle();
		$display("Checked %0d window means (%0d frame ends) from %0d pixels, %0d register writes,",
			mean_count, frame_count, pixel_count, write_count);
		$display("over directed, widest, tallest and %0d random phases.", phase);
		if (fail_count == 0 && mean_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
